// ----- hdl/tdve_pkg.sv -----
// shared types and constants for the timestamp delta-of-delta varint encoder
package tdve_pkg;

    localparam int RAW_BYTES = 8;
    localparam int RAW_CNT_W = $clog2(RAW_BYTES);

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_LATER  = 2'd2;

    typedef struct packed {
        logic signed [63:0] sample_time;
        logic               block_end;
    } in_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       item_done;
        logic       block_done;
    } out_t;

    typedef struct packed {
        logic [63:0] value;
        logic        raw;
        logic        last;
    } job_t;

endpackage

// ----- hdl/tdve_front.sv -----
// front end: takes timestamps, forms raw or zigzag delta jobs
module tdve_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  tdve_pkg::in_t item,
    output logic          job_valid,
    output tdve_pkg::job_t job,
    input  logic          job_ready
);

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [63:0] prev_time_reg;
    logic [63:0] last_delta_reg;
    logic        a_valid_reg;
    logic        a_valid_next;
    logic [1:0]  a_kind_reg;
    logic [63:0] a_time_reg;
    logic [63:0] a_delta_reg;
    logic        a_last_reg;
    logic        accept;
    logic        advance;
    logic [63:0] delta_in;
    logic [63:0] dod;
    logic [63:0] sel;
    logic [63:0] zz;

    assign full     = a_valid_reg && !job_ready;
    assign accept   = push && !full;
    assign advance  = a_valid_reg && job_ready;
    assign delta_in = 64'(item.sample_time) - prev_time_reg;

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (item.block_end)
                phase_next = tdve_pkg::PHASE_FIRST;
            else if (phase_reg == tdve_pkg::PHASE_FIRST)
                phase_next = tdve_pkg::PHASE_SECOND;
            else
                phase_next = tdve_pkg::PHASE_LATER;
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
            a_valid_next = 1'b1;
        else if (advance)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tdve_pkg::PHASE_FIRST;
            prev_time_reg  <= '0;
            last_delta_reg <= '0;
            a_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            a_valid_reg <= a_valid_next;
            if (accept)
                prev_time_reg <= 64'(item.sample_time);
            if (advance && a_kind_reg != tdve_pkg::PHASE_FIRST)
                last_delta_reg <= a_delta_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_kind_reg  <= phase_reg;
            a_time_reg  <= 64'(item.sample_time);
            a_delta_reg <= delta_in;
            a_last_reg  <= item.block_end;
        end
    end

    assign dod = a_delta_reg - last_delta_reg;
    assign sel = (a_kind_reg == tdve_pkg::PHASE_SECOND) ? a_delta_reg : dod;
    assign zz  = {sel[62:0], 1'b0} ^ {64{sel[63]}};

    assign job_valid = a_valid_reg;
    assign job.raw   = (a_kind_reg == tdve_pkg::PHASE_FIRST);
    assign job.value = job.raw ? a_time_reg : zz;
    assign job.last  = a_last_reg;

endmodule

// ----- hdl/tdve_queue.sv -----
// small register queue of jobs between front and back end
module tdve_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tdve_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output tdve_pkg::job_t pop_job,
    output logic           empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tdve_pkg::job_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ----- hdl/tdve_back.sv -----
// back end: serializes raw or varint jobs into output bytes
module tdve_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  tdve_pkg::job_t job,
    output logic           job_pop,
    output logic           empty,
    input  logic           pop,
    output tdve_pkg::out_t result
);

    localparam int CW = tdve_pkg::RAW_CNT_W;

    logic          busy_reg;
    logic          busy_next;
    logic [63:0]   val_reg;
    logic          raw_reg;
    logic          last_reg;
    logic [CW-1:0] cnt_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    tdve_pkg::out_t out_reg;
    logic          advance;
    logic          take;
    logic          more;
    logic [7:0]    cur_byte;
    logic          byte_last;

    assign more      = |val_reg[63:7];
    assign cur_byte  = raw_reg ? val_reg[7:0] : {more, val_reg[6:0]};
    assign byte_last = raw_reg ? (cnt_reg == CW'(tdve_pkg::RAW_BYTES - 1)) : !more;
    assign advance   = busy_reg && (!out_valid_reg || pop);
    assign take      = job_valid && (!busy_reg || (advance && byte_last));
    assign job_pop   = take;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        busy_next = busy_reg;
        if (take)
            busy_next = 1'b1;
        else if (advance && byte_last)
            busy_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            val_reg  <= job.value;
            raw_reg  <= job.raw;
            last_reg <= job.last;
            cnt_reg  <= '0;
        end
        else if (advance)
        begin
            val_reg <= raw_reg ? {8'd0, val_reg[63:8]} : {7'd0, val_reg[63:7]};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (advance)
        begin
            out_reg.code_byte  <= cur_byte;
            out_reg.item_done  <= byte_last;
            out_reg.block_done <= byte_last && last_reg;
        end
    end

endmodule

// ----- hdl/timestamp_dod_varint_encoder_core.sv -----
// top level of the timestamp delta-of-delta varint encoder
//
// channel   | request     | handshake
// ----------+-------------+-------------------------------
// input     | item        | push / full, taken when push && !full
// output    | result      | empty / pop, taken when pop && !empty
//
// one output byte per cycle while pop drains it and jobs wait, set by the single output byte register of the back end
// an item gives 8 raw bytes for the first of a block and 1 to 10 varint bytes otherwise
// a taken request passes the front job register, the job queue and the back end value register before its first byte
// front and back stall independently through a QUEUE_DEPTH entry job queue
// asynchronous reset returns phase to the first timestamp and empties all stages
module timestamp_dod_varint_encoder_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  tdve_pkg::in_t  item,
    output logic           empty,
    input  logic           pop,
    output tdve_pkg::out_t result
);

    logic           f_valid;
    tdve_pkg::job_t f_job;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    tdve_pkg::job_t q_job;

    tdve_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .job_valid (f_valid),
        .job       (f_job),
        .job_ready (!q_full)
    );

    tdve_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_valid),
        .push_job (f_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_job),
        .empty    (q_empty)
    );

    tdve_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (q_job),
        .job_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    a_block_done_on_item_end: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!result.block_done || result.item_done))
        else $error("block_done without item_done");

    a_queue_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue full and empty at once");

    a_stalled_job_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (f_valid && q_full) |=> (f_valid && $stable(f_job)))
        else $error("front job changed while queue full");

    a_pop_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end took a job from an empty queue");

endmodule

// ----- tb/sv/tb_timestamp_dod_varint_encoder_core.sv -----
// testbench for the timestamp delta-of-delta varint encoder core
`timescale 1ns / 100ps

module tb_timestamp_dod_varint_encoder_core;

    localparam int RANDOM_ITEMS = 205;
    localparam int TAIL_ITEMS   = 40;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           push = 1'b0;
    logic           full;
    tdve_pkg::in_t  item = '0;
    logic           empty;
    logic           pop = 1'b0;
    tdve_pkg::out_t result;

    tdve_pkg::in_t  pending_items[$];
    tdve_pkg::out_t expected_bytes[$];
    tdve_pkg::out_t want;

    logic [1:0]  enc_phase = tdve_pkg::PHASE_FIRST;
    logic [63:0] prev_time = '0;
    logic [63:0] last_delta = '0;

    int total_items = 0;
    int accepted_items = 0;
    int checked_bytes = 0;
    int blocks_seen = 0;
    int long_varints = 0;
    int full_stalls = 0;
    int error_count = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int hold_left = 0;
    bit pressure_done = 1'b0;

    timestamp_dod_varint_encoder_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #5 clk = ~clk;

    function automatic tdve_pkg::out_t code_entry(logic [7:0] b, logic item_last,
                                                  logic blk_last);
        tdve_pkg::out_t e;
        e.code_byte  = b;
        e.item_done  = item_last;
        e.block_done = item_last & blk_last;
        return e;
    endfunction

    task automatic encode_timestamp(input tdve_pkg::in_t req);
        logic [63:0] stamp;
        logic [63:0] delta;
        logic [63:0] residue;
        int n;
        stamp = req.sample_time;
        if (enc_phase == tdve_pkg::PHASE_FIRST)
        begin
            for (n = 0; n < tdve_pkg::RAW_BYTES; n++)
                expected_bytes.push_back(code_entry(stamp[8*n +: 8],
                                                    n == tdve_pkg::RAW_BYTES - 1,
                                                    req.block_end));
            enc_phase = tdve_pkg::PHASE_SECOND;
        end
        else
        begin
            delta   = stamp - prev_time;
            residue = (enc_phase == tdve_pkg::PHASE_SECOND) ? delta : delta - last_delta;
            // zigzag map
            residue = (residue << 1) ^ {64{residue[63]}};
            n = 0;
            while ((residue >> 7) != 0)
            begin
                expected_bytes.push_back(code_entry({1'b1, residue[6:0]}, 1'b0,
                                                    req.block_end));
                residue = residue >> 7;
                n++;
            end
            expected_bytes.push_back(code_entry({1'b0, residue[6:0]}, 1'b1, req.block_end));
            if (n == 9)
                long_varints++;
            last_delta = delta;
            enc_phase  = tdve_pkg::PHASE_LATER;
        end
        prev_time = stamp;
        if (req.block_end)
            enc_phase = tdve_pkg::PHASE_FIRST;
    endtask

    task automatic add_item(input logic [63:0] stamp, input logic last);
        tdve_pkg::in_t req;
        req.sample_time = stamp;
        req.block_end   = last;
        pending_items.push_back(req);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && full)
                full_stalls++;
            if (push && !full)
            begin
                encode_timestamp(item);
                void'(pending_items.pop_front());
                accepted_items++;
            end
            // a refused request stays on the port unchanged
            if (!(push && full))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    push <= 1'b0;
                end
                else if (pending_items.size() == 0)
                    push <= 1'b0;
                else if (accepted_items < total_items - TAIL_ITEMS
                         && (accepted_items / 30) % 3 != 2
                         && $urandom_range(0, 4) == 0)
                begin
                    tx_gap = $urandom_range(1, 7) - 1;
                    push <= 1'b0;
                end
                else
                begin
                    push <= 1'b1;
                    item <= pending_items[0];
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected byte: code_byte %02h item_done %0b block_done %0b",
                           result.code_byte, result.item_done, result.block_done);
                    error_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (result.code_byte !== want.code_byte)
                    begin
                        $error("code_byte: expected %02h, actual %02h",
                               want.code_byte, result.code_byte);
                        error_count++;
                    end
                    if (result.item_done !== want.item_done)
                    begin
                        $error("item_done: expected %0b, actual %0b",
                               want.item_done, result.item_done);
                        error_count++;
                    end
                    if (result.block_done !== want.block_done)
                    begin
                        $error("block_done: expected %0b, actual %0b",
                               want.block_done, result.block_done);
                        error_count++;
                    end
                end
                checked_bytes++;
                if (result.block_done === 1'b1)
                    blocks_seen++;
            end
            // long hold-off so the job queue fills and full backs up the sender
            if (!pressure_done && checked_bytes >= 120)
            begin
                pressure_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                pop <= 1'b0;
            end
            else if (accepted_items < total_items - TAIL_ITEMS
                     && (checked_bytes / 100) % 3 != 1
                     && $urandom_range(0, 5) == 0)
            begin
                rx_gap = $urandom_range(1, 7) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        logic [63:0] base;
        logic [63:0] stamp;
        logic [63:0] period;
        logic [63:0] jitter;
        int blk_len;
        int k;
        int target;
        bit noise;

        base = 64'h0123_4567_89AB_CDEF;

        // blocks of one item at the extremes
        add_item(64'h0, 1'b1);
        add_item(64'h8000_0000_0000_0000, 1'b1);
        add_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        add_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        // small deltas, zero residue and the one/two byte varint boundary
        add_item(base, 1'b0);
        add_item(base + 64'd1, 1'b0);
        add_item(base + 64'd2, 1'b0);
        add_item(base - 64'd61, 1'b0);
        add_item(base - 64'd60, 1'b1);
        // delta of most negative value gives a ten byte varint
        add_item(64'h0, 1'b0);
        add_item(64'h8000_0000_0000_0000, 1'b1);
        // largest delta then delta of deltas at the most negative value
        add_item(64'h0, 1'b0);
        add_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        add_item(64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
        add_item(64'h7FFF_FFFF_FFFF_FFFE, 1'b1);
        // delta that wraps past the top
        add_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        add_item(64'h8000_0000_0000_0000, 1'b1);

        target = pending_items.size() + RANDOM_ITEMS;
        while (pending_items.size() < target)
        begin
            blk_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            noise   = ($urandom_range(0, 7) == 0);
            stamp   = {$urandom, $urandom};
            period  = {$urandom, $urandom} >> $urandom_range(20, 63);
            for (k = 0; k < blk_len; k++)
            begin
                add_item(stamp, k == blk_len - 1);
                jitter = {$urandom, $urandom} >> $urandom_range(0, 63);
                if ($urandom_range(0, 1) == 1)
                    jitter = -jitter;
                if ($urandom_range(0, 3) == 0)
                    jitter = '0;
                stamp = noise ? {$urandom, $urandom} : stamp + period + jitter;
            end
        end
        total_items = pending_items.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_items < total_items || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (expected_bytes.size() != 0)
        begin
            $error("%0d expected bytes never arrived", expected_bytes.size());
            error_count++;
        end

        $display("run covered %0d timestamps, %0d closed blocks, %0d bytes compared",
                 accepted_items, blocks_seen, checked_bytes);
        $display("ten byte varints seen: %0d, cycles with a request held off by full: %0d",
                 long_varints, full_stalls);
        if (error_count == 0)
            $display("timestamp_dod_varint_encoder_core verification clean");
        else
            $display("timestamp_dod_varint_encoder_core verification failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("timestamp_dod_varint_encoder_core verification failed");
        $finish;
    end

endmodule
